/* design/sgc_pkg.sv */
// Package for the stepper gate controller: gate mode codes, register
// indexes, reset values and the four-phase coil tables.
// No dependencies.
package sgc_pkg;

    // Gate mode codes as reported on the result stream
    typedef enum logic [2:0] {
        GATE_CLOSING = 3'd0,
        GATE_CLOSED  = 3'd1,
        GATE_OPENING = 3'd2,
        GATE_OPENED  = 3'd3,
        GATE_BUSY    = 3'd4
    } gate_mode_t;

    // Configuration register indexes (paddr[2])
    localparam logic REG_STEP_PERIOD   = 1'b0;
    localparam logic REG_TRAVEL_CYCLES = 1'b1;

    localparam logic [7:0] STEP_PERIOD_RST   = 8'd10;
    localparam logic [7:0] TRAVEL_CYCLES_RST = 8'd60;
    localparam logic [7:0] COIL_RST          = 8'hff;
    localparam logic [7:0] EMERGENCY_BYTE    = 8'hff;

    // Stream payload widths
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Forward (closing) double-phase pattern
    function automatic logic [7:0] fwd_coil(input logic [1:0] ph);
        logic [7:0] pat;
        begin
            case (ph)
                2'd0:    pat = 8'hf3;
                2'd1:    pat = 8'hf9;
                2'd2:    pat = 8'hfc;
                default: pat = 8'hf6;
            endcase
            return pat;
        end
    endfunction

    // Reverse (opening) double-phase pattern
    function automatic logic [7:0] rev_coil(input logic [1:0] ph);
        logic [7:0] pat;
        begin
            case (ph)
                2'd0:    pat = 8'hf3;
                2'd1:    pat = 8'hf6;
                2'd2:    pat = 8'hfc;
                default: pat = 8'hf9;
            endcase
            return pat;
        end
    endfunction

endpackage

/* design/stepper_gate_controller.sv */
// Stepper gate controller top level: tick stream in, coil pattern and
// gate state out, APB-style register port.
// Depends on sgc_pkg.

// One input beat is one timer tick and yields exactly one result beat.
// The block takes a tick on every clock while the output is not stalled: a tick
// is held in the input register, the gate logic then updates its counters and
// writes the result register, which drives the output. s_tready follows m_tready
// combinationally through the two-stage pipeline; with the output stalled,
// up to two ticks are held (result register plus input register).
// Registers: step_period at 0x0 (reset 10), travel_cycles at 0x4 (reset 60);
// write them only while no tick is in flight.
module stepper_gate_controller
    import sgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tick stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] toggle_request, [8:1] rx_byte, rest 0
    input  logic                  s_tuser,   // [0] rx_valid
    // result stream out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] coil_drive, [10:8] gate_state, rest 0
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // configuration registers
    logic [7:0] step_period_reg;
    logic [7:0] travel_cycles_reg;

    // input stage
    logic       in_valid_reg;
    logic       in_toggle_reg;
    logic       in_rx_valid_reg;
    logic [7:0] in_rx_byte_reg;

    // gate state
    logic [7:0] prescale_reg, prescale_next;
    gate_mode_t mode_reg, mode_next;
    gate_mode_t target_reg, target_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] cycle_reg, cycle_next;
    logic [7:0] coil_reg, coil_next;

    // result stage
    logic       out_valid_reg;
    logic [7:0] out_coil_reg;
    gate_mode_t out_mode_reg;

    logic advance;
    logic cfg_write;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_period_reg   <= STEP_PERIOD_RST;
            travel_cycles_reg <= TRAVEL_CYCLES_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_STEP_PERIOD)
                step_period_reg <= pwdata[7:0];
            else
                travel_cycles_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_STEP_PERIOD)
            prdata = {24'd0, step_period_reg};
        else
            prdata = {24'd0, travel_cycles_reg};
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_toggle_reg   <= s_tdata[0];
            in_rx_byte_reg  <= s_tdata[8:1];
            in_rx_valid_reg <= s_tuser;
        end
    end

    // one tick: prescaler and motor step, then toggle, then serial byte
    always_comb
    begin
        logic [7:0] pre_inc;
        logic [7:0] cyc_inc;
        logic       fire;
        logic       do_step;
        logic       use_fwd;

        pre_inc     = prescale_reg + 8'd1;
        fire        = (pre_inc >= step_period_reg);
        prescale_next = fire ? 8'd0 : pre_inc;

        mode_next   = mode_reg;
        target_next = target_reg;
        phase_next  = phase_reg;
        cycle_next  = cycle_reg;
        coil_next   = coil_reg;
        do_step     = 1'b0;
        use_fwd     = 1'b0;
        cyc_inc     = cycle_reg + 8'd1;

        // motor step: work out direction and whether the step applies
        if (fire)
        begin
            unique case (mode_reg)
                GATE_CLOSING:
                begin
                    do_step     = 1'b1;
                    use_fwd     = 1'b1;
                    target_next = GATE_CLOSED;
                    mode_next   = GATE_BUSY;
                end
                GATE_OPENING:
                begin
                    do_step     = 1'b1;
                    use_fwd     = 1'b0;
                    target_next = GATE_OPENED;
                    mode_next   = GATE_BUSY;
                end
                GATE_BUSY:
                begin
                    do_step = (target_reg == GATE_CLOSED) || (target_reg == GATE_OPENED);
                    use_fwd = (target_reg == GATE_CLOSED);
                end
                default:
                begin
                    do_step = 1'b0;
                end
            endcase
        end

        // advance phase and count full cycles
        if (do_step)
        begin
            coil_next  = use_fwd ? fwd_coil(phase_reg) : rev_coil(phase_reg);
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                if (cyc_inc >= travel_cycles_reg)
                begin
                    mode_next  = target_next;
                    cycle_next = 8'd0;
                end
                else
                begin
                    cycle_next = cyc_inc;
                end
            end
        end

        // toggle request reverses the gate, also while moving
        if (in_toggle_reg)
        begin
            case (mode_next)
                GATE_BUSY:
                begin
                    if (target_next == GATE_OPENED)
                        mode_next = GATE_CLOSING;
                    else if (target_next == GATE_CLOSED)
                        mode_next = GATE_OPENING;
                end
                GATE_CLOSED: mode_next = GATE_OPENING;
                GATE_OPENED: mode_next = GATE_CLOSING;
                default:     mode_next = mode_next;
            endcase
        end

        // emergency byte toggles only at rest
        if (in_rx_valid_reg && (in_rx_byte_reg == EMERGENCY_BYTE))
        begin
            if (mode_next == GATE_CLOSED)
                mode_next = GATE_OPENING;
            else if (mode_next == GATE_OPENED)
                mode_next = GATE_CLOSING;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= 8'd0;
            mode_reg      <= GATE_CLOSED;
            target_reg    <= GATE_BUSY;
            phase_reg     <= 2'd0;
            cycle_reg     <= 8'd0;
            coil_reg      <= COIL_RST;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                prescale_reg <= prescale_next;
                mode_reg     <= mode_next;
                target_reg   <= target_next;
                phase_reg    <= phase_next;
                cycle_reg    <= cycle_next;
                coil_reg     <= coil_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_coil_reg <= coil_next;
            out_mode_reg <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_mode_reg, out_coil_reg};

endmodule

/* design/sgc_checker.sv */
// Port-level checker for the stepper gate controller, bound to the top.
// Depends on stepper_gate_controller.
module sgc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // the upper port nibble is never driven low
    a_coil_high: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'hf)
        else $error("coil upper nibble not all ones");

    // phases are either all released or exactly two energized
    a_coil_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] == 4'hf) || ($countones(m_tdata[3:0]) == 2))
        else $error("coil pattern is not a double-phase step");

    // padding above gate_state stays zero
    a_rest_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("result padding bits set");

endmodule

bind stepper_gate_controller sgc_checker u_sgc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb_stepper_gate_controller.sv */
// Testbench for stepper_gate_controller: drives timer ticks on the input stream,
// predicts coil pattern and gate state per tick, and checks the result stream.
// Depends on sgc_pkg and the stepper_gate_controller RTL.
module tb_stepper_gate_controller;
    import sgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DIR_ROWS    = 20;
    localparam int NUM_PHASES  = 9;

    // Coil patterns packed per phase, phase 0 in the low byte
    localparam logic [31:0] CLOSE_SEQ = 32'hf6fcf9f3;
    localparam logic [31:0] OPEN_SEQ  = 32'hf9fcf6f3;

    typedef struct packed {
        logic [7:0] coil;
        gate_mode_t state;
    } gate_result_t;

    typedef struct {
        logic         tog;
        logic         rxv;
        logic [7:0]   rxb;
        bit           typed;
        gate_result_t want;
    } tick_row_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;  // [0] toggle_request, [8:1] rx_byte
    logic                  s_tuser  = 1'b0; // [0] rx_valid
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [7:0] coil_drive, [10:8] gate_state
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predictor copy of the gate state and registers
    logic [7:0] period_cfg;
    logic [7:0] travel_cfg;
    logic [7:0] ticks_since_step;
    logic [1:0] coil_phase;
    logic [7:0] turns_done;
    logic [7:0] coil_now;
    gate_mode_t gate_now;
    gate_mode_t gate_goal;

    gate_result_t gate_outputs_due[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    tick_row_t    dir_rows[DIR_ROWS];

    stepper_gate_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // One timer tick: prescaler and motor step, then toggle, then serial byte
    function automatic gate_result_t predict_tick(input logic tog, input logic rxv,
                                                  input logic [7:0] rxb);
        gate_result_t r;
        logic         driven;
        ticks_since_step = ticks_since_step + 8'd1;
        if (ticks_since_step >= period_cfg)
        begin
            ticks_since_step = 8'd0;
            driven = 1'b1;
            if (gate_now == GATE_CLOSING)
            begin
                gate_goal = GATE_CLOSED;
                gate_now  = GATE_BUSY;
            end
            else if (gate_now == GATE_OPENING)
            begin
                gate_goal = GATE_OPENED;
                gate_now  = GATE_BUSY;
            end
            else if (gate_now != GATE_BUSY)
                driven = 1'b0;  // at rest, phase holds
            if (driven && gate_goal == GATE_CLOSED)
                coil_now = CLOSE_SEQ[{coil_phase, 3'b000} +: 8];
            else if (driven && gate_goal == GATE_OPENED)
                coil_now = OPEN_SEQ[{coil_phase, 3'b000} +: 8];
            else
                driven = 1'b0;
            if (driven)
            begin
                // full cycle done: count it, settle once travel is complete
                if (coil_phase == 2'd3)
                begin
                    turns_done = turns_done + 8'd1;
                    if (turns_done >= travel_cfg)
                    begin
                        gate_now   = gate_goal;
                        turns_done = 8'd0;
                    end
                end
                coil_phase = coil_phase + 2'd1;
            end
        end
        if (tog)
        begin
            case (gate_now)
                GATE_BUSY:
                begin
                    if (gate_goal == GATE_OPENED)
                        gate_now = GATE_CLOSING;
                    else if (gate_goal == GATE_CLOSED)
                        gate_now = GATE_OPENING;
                end
                GATE_CLOSED: gate_now = GATE_OPENING;
                GATE_OPENED: gate_now = GATE_CLOSING;
                default: ;
            endcase
        end
        // emergency byte only acts at rest
        if (rxv && rxb == EMERGENCY_BYTE)
        begin
            if (gate_now == GATE_CLOSED)
                gate_now = GATE_OPENING;
            else if (gate_now == GATE_OPENED)
                gate_now = GATE_CLOSING;
        end
        r.coil  = coil_now;
        r.state = gate_now;
        return r;
    endfunction

    // Send one tick beat, record its expected result once accepted
    task automatic send_tick(input logic tog, input logic rxv, input logic [7:0] rxb,
                             input bit typed, input gate_result_t want);
        gate_result_t exp_res;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, rxb, tog};
        s_tuser  <= rxv;
        do @(posedge clk); while (!s_tready);
        exp_res = predict_tick(tog, rxv, rxb);
        if (typed)
            exp_res = want;
        gate_outputs_due.push_back(exp_res);
    endtask

    task automatic send_random_tick();
        logic       tog;
        logic       rxv;
        logic [7:0] rxb;
        tog = ($urandom_range(0, 15) == 0);
        rxv = ($urandom_range(0, 3) == 0);
        rxb = ($urandom_range(0, 3) == 0) ? EMERGENCY_BYTE : 8'($urandom_range(0, 255));
        send_tick(tog, rxv, rxb, 1'b0, '0);
    endtask

    // Hold off until every result is back, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (gate_outputs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write followed by a readback
    task automatic reg_write(input logic idx, input logic [7:0] val);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (readback !== {24'd0, val})
        begin
            $error("register %0d readback: expected %0d, actual %0d", idx, val, readback);
            fail_count++;
        end
        if (idx == REG_STEP_PERIOD)
            period_cfg = val;
        else
            travel_cfg = val;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        gate_result_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (gate_outputs_due.size() == 0)
            begin
                $error("unexpected result beat: coil_drive %0h gate_state %0d",
                       m_tdata[7:0], m_tdata[10:8]);
                fail_count++;
            end
            else
            begin
                due = gate_outputs_due.pop_front();
                if (m_tdata[7:0] !== due.coil)
                begin
                    $error("coil_drive mismatch: expected %0h, actual %0h",
                           due.coil, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[10:8] !== due.state)
                begin
                    $error("gate_state mismatch: expected %0d, actual %0d",
                           due.state, m_tdata[10:8]);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: picks a new random stall pattern for each random-length span
    initial
    begin
        int mode;
        int span;
        int k;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            for (k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (k % 4 != 3);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] phase_period[NUM_PHASES];
        logic [7:0] phase_travel[NUM_PHASES];
        int         phase_items[NUM_PHASES];
        int         ph;
        int         r;
        int         sent;
        int         burst;
        int         gap;

        period_cfg       = STEP_PERIOD_RST;
        travel_cfg       = TRAVEL_CYCLES_RST;
        ticks_since_step = 8'd0;
        coil_phase       = 2'd0;
        turns_done       = 8'd0;
        coil_now         = COIL_RST;
        gate_now         = GATE_CLOSED;
        gate_goal        = GATE_BUSY;

        // Directed ticks at reset settings (period 10, travel 60)
        dir_rows[0]  = '{1'b0, 1'b0, 8'h00, 1'b1, '{8'hff, GATE_CLOSED}};
        dir_rows[1]  = '{1'b0, 1'b1, 8'hfe, 1'b1, '{8'hff, GATE_CLOSED}};  // non-emergency byte
        dir_rows[2]  = '{1'b0, 1'b0, 8'hff, 1'b1, '{8'hff, GATE_CLOSED}};  // byte without valid
        dir_rows[3]  = '{1'b0, 1'b1, 8'hff, 1'b1, '{8'hff, GATE_OPENING}}; // emergency at rest
        dir_rows[4]  = '{1'b1, 1'b1, 8'hff, 1'b1, '{8'hff, GATE_OPENING}}; // no effect pre-step
        dir_rows[5]  = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[6]  = '{1'b0, 1'b1, 8'h55, 1'b0, '0};
        dir_rows[7]  = '{1'b0, 1'b1, 8'haa, 1'b0, '0};
        dir_rows[8]  = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[9]  = '{1'b0, 1'b0, 8'h00, 1'b1, '{8'hf3, GATE_BUSY}};    // first step
        dir_rows[10] = '{1'b1, 1'b0, 8'h00, 1'b1, '{8'hf3, GATE_CLOSING}}; // reverse mid-travel
        dir_rows[11] = '{1'b1, 1'b1, 8'hff, 1'b0, '0};
        dir_rows[12] = '{1'b0, 1'b1, 8'h80, 1'b0, '0};
        dir_rows[13] = '{1'b0, 1'b1, 8'h7f, 1'b0, '0};
        dir_rows[14] = '{1'b0, 1'b1, 8'h01, 1'b0, '0};
        dir_rows[15] = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[16] = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[17] = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[18] = '{1'b0, 1'b0, 8'h00, 1'b0, '0};
        dir_rows[19] = '{1'b1, 1'b1, 8'hff, 1'b0, '0};  // toggle and byte together

        // Register settings per random phase: zeros, extremes, lowered limits
        phase_period = '{8'd0, 8'd1, 8'd255, 8'd1, 8'd255, 8'd3, 8'd2, 8'd0, 8'd10};
        phase_travel = '{8'd0, 8'd1, 8'd255, 8'd255, 8'd1, 8'd2, 8'd1, 8'd0, 8'd60};
        phase_items  = '{100, 150, 80, 100, 80, 150, 150, 120, 80};
        phase_period[7] = 8'($urandom_range(1, 4));
        phase_travel[7] = 8'($urandom_range(1, 4));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            send_tick(dir_rows[r].tog, dir_rows[r].rxv, dir_rows[r].rxb,
                      dir_rows[r].typed, dir_rows[r].want);

        // Random phases, registers rewritten once the pipeline is empty
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            reg_write(REG_STEP_PERIOD, phase_period[ph]);
            reg_write(REG_TRAVEL_CYCLES, phase_travel[ph]);
            @(posedge clk);
            sent = 0;
            while (sent < phase_items[ph])
            begin
                burst = $urandom_range(1, 24);
                for (r = 0; r < burst && sent < phase_items[ph]; r++)
                begin
                    send_random_tick();
                    sent++;
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
